// ----- src/line_position_pid_macros.svh -----
// assertion macros for the line position pid block
// used by the top level only, no other dependencies
`ifndef LINE_POSITION_PID_MACROS_SVH
`define LINE_POSITION_PID_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LPP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// next-cycle implication
`define LPP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define LPP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg)
`define LPP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ----- src/lpp_pkg.sv -----
// shared constants and types for the line position pid block
// no dependencies
`timescale 1ns / 1ps

package lpp_pkg;

	// defaults of the top level parameters
	localparam int ZONE_PIXELS_DEF = 40;
	localparam int ZONE_COUNT_DEF  = 8;
	localparam int INPUT_ZONES     = 8;

	// zone offset base, 1/16 pixel
	localparam int OFFSET_BASE = -2232;

	// field widths
	localparam int CNT_W   = 6;
	localparam int SP_W    = 13;
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 13;
	localparam int SUM_W   = 24;
	localparam int DRIVE_W = 8;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int ACC_W   = GAIN_W + SUM_W + 2;
	localparam int PCNT_W  = $clog2(GAIN_W + 1);

	// drive value is acc scaled down by 2^12
	localparam int DRIVE_SHIFT = 12;

	localparam int ERR_MIN = -(2 ** (ERR_W - 1));
	localparam int ERR_MAX = (2 ** (ERR_W - 1)) - 1;
	localparam int SUM_MIN = -(2 ** (SUM_W - 1));
	localparam int SUM_MAX = (2 ** (SUM_W - 1)) - 1;

	// configuration register map
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 4'd3;

	localparam logic signed [SP_W-1:0] SETPOINT_RST = 13'sd592;
	localparam logic [GAIN_W-1:0]      GAIN_P_RST   = 16'd2560;
	localparam logic [GAIN_W-1:0]      GAIN_I_RST   = 16'd0;
	localparam logic [GAIN_W-1:0]      GAIN_D_RST   = 16'd0;

	// divider widths for the default zone setup
	localparam int DIV_DVD_W_DEF = 23;
	localparam int DIV_DVS_W_DEF = 10;
	localparam int DIV_Q_W_DEF   = 12;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- src/lpp_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on lpp_pkg for the status struct and the default widths
`timescale 1ns / 1ps

module lpp_div #(
	parameter int DVD_W = lpp_pkg::DIV_DVD_W_DEF,
	parameter int DVS_W = lpp_pkg::DIV_DVS_W_DEF,
	parameter int Q_W   = lpp_pkg::DIV_Q_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVS_W-1:0]     divisor,
	output lpp_pkg::div_sts_t    sts,
	output logic [Q_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [Q_W-1:0]   lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   diff;

	// quotient is known to fit Q_W bits, so the top part starts below the divisor
	assign trial = {rem_q, lo_q[Q_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[Q_W+DVS_W-1:Q_W];
			lo_q  <= dividend[Q_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			lo_q  <= {lo_q[Q_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = lo_q;

endmodule

// ----- src/line_position_pid.sv -----
// line position pid: zone centroid, position error and saturated pid drive value
// depends on lpp_pkg, lpp_div and line_position_pid_macros.svh
`timescale 1ns / 1ps
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  --------------------------------------
// in        sink       in_valid / in_stall    zone_count_0 .. zone_count_7
// out       source     out_valid / out_stall  drive_value, position_error, line_lost
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request at a time; with the default zone setup a request passes 8 zone
// steps, 12 divider steps and 16 gain bits, and one with no zone weight skips
// the divider and the pid; the zone multiply-accumulate, the serial divider
// and the bit-serial pid multiply run one after another
// reset clears the sequencer, the pid state and loads the register defaults
// a finished result waits in the output register; the next request is taken
// meanwhile, only a second finished result waits for out_stall to drop

module line_position_pid #(
	parameter int ZONE_PIXELS = lpp_pkg::ZONE_PIXELS_DEF,
	parameter int ZONE_COUNT  = lpp_pkg::ZONE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_0,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_1,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_2,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_3,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_4,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_5,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_6,
	input  logic [lpp_pkg::CNT_W-1:0]         zone_count_7,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lpp_pkg::DRIVE_W-1:0]       drive_value,
	output logic signed [lpp_pkg::ERR_W-1:0]  position_error,
	output logic                              line_lost,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpp_pkg::GAIN_W-1:0]        cfg_data
);

`include "line_position_pid_macros.svh"

	// zones beyond the input fields carry no weight, so they are never visited
	localparam int USED      = (ZONE_COUNT < lpp_pkg::INPUT_ZONES) ? ZONE_COUNT
	                                                               : lpp_pkg::INPUT_ZONES;
	localparam int WGT_W     = $clog2(ZONE_PIXELS + 1);
	localparam int CMP_W     = (WGT_W > lpp_pkg::CNT_W) ? WGT_W : lpp_pkg::CNT_W;
	localparam int DEN_W     = $clog2(USED * ZONE_PIXELS + 1);
	localparam int ZCNT_W    = $clog2(USED + 1);
	localparam int OFF_STEP  = 16 * ZONE_PIXELS;
	localparam int OFF_FIRST = lpp_pkg::OFFSET_BASE + OFF_STEP;
	localparam int OFF_LAST  = lpp_pkg::OFFSET_BASE + OFF_STEP * USED;
	localparam int ABS_FIRST = (OFF_FIRST < 0) ? -OFF_FIRST : OFF_FIRST;
	localparam int ABS_LAST  = (OFF_LAST < 0) ? -OFF_LAST : OFF_LAST;
	localparam int OFF_MAX   = (ABS_FIRST > ABS_LAST) ? ABS_FIRST : ABS_LAST;
	localparam int Q_W       = $clog2(OFF_MAX + 1);
	localparam int OFF_W     = Q_W + 1;
	localparam int CEN_W     = Q_W + 1;
	localparam int NUM_W     = Q_W + DEN_W + 1;
	localparam int MAG_W     = NUM_W - 1;
	localparam int PROD_W    = WGT_W + 1 + OFF_W;
	localparam int DVD_W     = MAG_W + 2;
	localparam int DVS_W     = DEN_W + 1;
	localparam int ERW       = ((lpp_pkg::SP_W > CEN_W) ? lpp_pkg::SP_W : CEN_W) + 1;
	localparam int SRW       = lpp_pkg::SUM_W + 1;
	localparam int ACC_W     = lpp_pkg::ACC_W;
	localparam int GAIN_W    = lpp_pkg::GAIN_W;
	localparam int ERR_W     = lpp_pkg::ERR_W;
	localparam int SUM_W     = lpp_pkg::SUM_W;
	localparam int DIFF_W    = lpp_pkg::DIFF_W;
	localparam int PCNT_W    = lpp_pkg::PCNT_W;
	localparam int DRV_LO    = lpp_pkg::DRIVE_SHIFT;
	localparam int DRV_HI    = lpp_pkg::DRIVE_SHIFT + lpp_pkg::DRIVE_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ACC  = 8'b0000_0010,
		ST_CHK  = 8'b0000_0100,
		ST_DIV  = 8'b0000_1000,
		ST_ERR  = 8'b0001_0000,
		ST_SUM  = 8'b0010_0000,
		ST_PID  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [lpp_pkg::SP_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]               gain_p_q;
	logic [GAIN_W-1:0]               gain_i_q;
	logic [GAIN_W-1:0]               gain_d_q;

	// pid state
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] last_error_q;

	// zone accumulation
	logic [lpp_pkg::CNT_W-1:0] cnt_in [lpp_pkg::INPUT_ZONES];
	logic [WGT_W-1:0]          wgt_in [USED];
	logic [WGT_W-1:0]          wgt_q  [USED];
	logic [ZCNT_W-1:0]         zcnt_q;
	logic signed [OFF_W-1:0]   off_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [PROD_W-1:0]  prod;

	// divide and error
	logic                      neg_q;
	logic                      lost_q;
	logic [MAG_W-1:0]          mag;
	logic [DVD_W-1:0]          dividend;
	logic                      div_start;
	lpp_pkg::div_sts_t         div_sts;
	logic [Q_W-1:0]            quotient;
	logic signed [CEN_W-1:0]   cen_q;
	logic signed [ERW-1:0]     err_raw;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [SRW-1:0]     sum_raw;
	logic signed [SUM_W-1:0]   esum_q;
	logic signed [DIFF_W-1:0]  diff_q;

	// bit-serial pid multiply, gain bits msb first
	logic [GAIN_W-1:0]         gp_sr_q;
	logic [GAIN_W-1:0]         gi_sr_q;
	logic [GAIN_W-1:0]         gd_sr_q;
	logic [PCNT_W-1:0]         pcnt_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_next;
	logic [lpp_pkg::DRIVE_W-1:0] drive;

	// output register
	logic                      out_valid_q;
	logic                      out_load;

	assign cnt_in[0] = zone_count_0;
	assign cnt_in[1] = zone_count_1;
	assign cnt_in[2] = zone_count_2;
	assign cnt_in[3] = zone_count_3;
	assign cnt_in[4] = zone_count_4;
	assign cnt_in[5] = zone_count_5;
	assign cnt_in[6] = zone_count_6;
	assign cnt_in[7] = zone_count_7;

	// weight = zone width minus the count, count clamped to the zone width
	always_comb begin
		for (int i = 0; i < USED; i++) begin
			if (CMP_W'(cnt_in[i]) > CMP_W'(ZONE_PIXELS)) begin
				wgt_in[i] = '0;
			end else begin
				wgt_in[i] = WGT_W'(CMP_W'(ZONE_PIXELS) - CMP_W'(cnt_in[i]));
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// one zone per cycle: weight times its offset
	assign prod = $signed({1'b0, wgt_q[0]}) * off_q;

	// the sign comes straight from the sum, the divider loads in the check step
	assign mag       = num_q[NUM_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
	// round half away from zero: (2*mag + den) / (2*den)
	assign dividend  = {1'b0, mag, 1'b0} + DVD_W'(den_q);
	assign div_start = (state_q == ST_CHK) && (den_q != '0);

	lpp_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W),
		.Q_W  (Q_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor ({den_q, 1'b0}),
		.sts     (div_sts),
		.quotient(quotient)
	);

	assign err_raw = ERW'(setpoint_q) - ERW'(cen_q);
	assign sum_raw = SRW'(error_sum_q) + SRW'(err_q);

	assign acc_next = (acc_q <<< 1)
		+ (gp_sr_q[GAIN_W-1] ? ACC_W'(err_q)  : ACC_W'(0))
		+ (gi_sr_q[GAIN_W-1] ? ACC_W'(esum_q) : ACC_W'(0))
		+ (gd_sr_q[GAIN_W-1] ? ACC_W'(diff_q) : ACC_W'(0));

	// zero when not positive, else acc >> 12 saturated to a byte
	always_comb begin
		if (acc_q[ACC_W-1] || (acc_q == '0)) begin
			drive = '0;
		end else if (|acc_q[ACC_W-2:DRV_HI]) begin
			drive = '1;
		end else begin
			drive = acc_q[DRV_HI-1:DRV_LO];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= lpp_pkg::SETPOINT_RST;
			gain_p_q   <= lpp_pkg::GAIN_P_RST;
			gain_i_q   <= lpp_pkg::GAIN_I_RST;
			gain_d_q   <= lpp_pkg::GAIN_D_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lpp_pkg::CFG_SETPOINT: setpoint_q <= cfg_data[lpp_pkg::SP_W-1:0];
				lpp_pkg::CFG_GAIN_P:   gain_p_q   <= cfg_data;
				lpp_pkg::CFG_GAIN_I:   gain_i_q   <= cfg_data;
				lpp_pkg::CFG_GAIN_D:   gain_d_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and pid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			error_sum_q  <= '0;
			last_error_q <= '0;
			zcnt_q       <= '0;
			pcnt_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						zcnt_q  <= ZCNT_W'(USED);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					zcnt_q <= zcnt_q - ZCNT_W'(1);
					if (zcnt_q == ZCNT_W'(1)) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					// an all-zero weight sum skips straight to the result
					state_q <= (den_q == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					pcnt_q  <= PCNT_W'(GAIN_W);
					state_q <= ST_PID;
				end
				ST_PID: begin
					pcnt_q <= pcnt_q - PCNT_W'(1);
					if (pcnt_q == PCNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						if (!lost_q) begin
							error_sum_q  <= esum_q;
							last_error_q <= err_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			wgt_q <= wgt_in;
			off_q <= OFF_W'(OFF_FIRST);
			num_q <= '0;
			den_q <= '0;
		end
		if (state_q == ST_ACC) begin
			for (int i = 0; i < USED - 1; i++) begin
				wgt_q[i] <= wgt_q[i+1];
			end
			wgt_q[USED-1] <= '0;
			off_q <= off_q + OFF_W'(OFF_STEP);
			num_q <= num_q + NUM_W'(prod);
			den_q <= den_q + DEN_W'(wgt_q[0]);
		end
		if (state_q == ST_CHK) begin
			neg_q  <= num_q[NUM_W-1];
			lost_q <= (den_q == '0);
		end
		if ((state_q == ST_DIV) && div_sts.done) begin
			cen_q <= neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
		end
		if (state_q == ST_ERR) begin
			if (err_raw < ERW'(lpp_pkg::ERR_MIN)) begin
				err_q <= ERR_W'(lpp_pkg::ERR_MIN);
			end else if (err_raw > ERW'(lpp_pkg::ERR_MAX)) begin
				err_q <= ERR_W'(lpp_pkg::ERR_MAX);
			end else begin
				err_q <= err_raw[ERR_W-1:0];
			end
		end
		if (state_q == ST_SUM) begin
			if (sum_raw < SRW'(lpp_pkg::SUM_MIN)) begin
				esum_q <= SUM_W'(lpp_pkg::SUM_MIN);
			end else if (sum_raw > SRW'(lpp_pkg::SUM_MAX)) begin
				esum_q <= SUM_W'(lpp_pkg::SUM_MAX);
			end else begin
				esum_q <= sum_raw[SUM_W-1:0];
			end
			diff_q  <= DIFF_W'(err_q) - DIFF_W'(last_error_q);
			gp_sr_q <= gain_p_q;
			gi_sr_q <= gain_i_q;
			gd_sr_q <= gain_d_q;
			acc_q   <= '0;
		end
		if (state_q == ST_PID) begin
			acc_q   <= acc_next;
			gp_sr_q <= gp_sr_q << 1;
			gi_sr_q <= gi_sr_q << 1;
			gd_sr_q <= gd_sr_q << 1;
		end
		if (out_load) begin
			drive_value    <= lost_q ? '0 : drive;
			position_error <= lost_q ? '0 : err_q;
			line_lost      <= lost_q;
		end
	end

	assign out_valid = out_valid_q;

	// a lost line reports zeros
	`LPP_ASSERT_IMP(a_lost_zero, clk, arst_n, out_valid && line_lost,
		(drive_value == '0) && (position_error == '0), "lost result is not zero")
	// divider finishes only while the sequencer waits for it
	`LPP_ASSERT_IMP(a_div_done_state, clk, arst_n, div_sts.done,
		state_q == ST_DIV, "divider done outside the divide step")
	// a lost line leaves the pid state alone
	`LPP_ASSERT_NXT(a_lost_keeps_state, clk, arst_n, (state_q == ST_DONE) && lost_q,
		$stable(error_sum_q) && $stable(last_error_q), "pid state changed on lost line")

endmodule

// ----- dv/tb.sv -----
// self-checking bench for line_position_pid: zone frames in, pid drive value and error out
// depends on lpp_pkg and the line_position_pid rtl, no other files
`timescale 1ns / 1ps

module tb;
	import lpp_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int ZONES       = ZONE_COUNT_DEF;
	localparam int ZONE_W      = ZONE_PIXELS_DEF;
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam int SUBPIX      = 16;
	localparam int DRIVE_MAX   = (1 << DRIVE_W) - 1;
	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
	// centroid range with the default zone layout, 1/16 pixel
	localparam int CENTROID_LO = OFFSET_BASE + SUBPIX * ZONE_W;
	localparam int CENTROID_HI = OFFSET_BASE + SUBPIX * ZONE_W * ZONES;
	// setpoint write data at the two ends of the 13 bit range
	localparam logic [GAIN_W-1:0] SP_MAX_DATA = 16'h0FFF;
	localparam logic [GAIN_W-1:0] SP_MIN_DATA = 16'h1000;
	// first index past the register map, the rest of the index space is unused
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_GAIN_D + 1);
	localparam int SPARE_SLOTS = (1 << CFG_IDX_W) - 1 - CFG_SPARE;
	// give the block a margin before register writes and at the end of the run
	localparam int DRAIN_CYC  = 48;
	localparam int TAIL_CYC   = 100;
	localparam int STALL_LIMIT = 2000;
	// random part: long drifts that wind the error sum far up and down, then general segments
	localparam int SEGMENTS    = 9;
	localparam int SEG_FRAMES  = 125;
	localparam int RISE_FRAMES = 300;
	localparam int FALL_FRAMES = 300;

	typedef logic [ZONES-1:0][CNT_W-1:0] zones_t;
	typedef enum logic {REQ_FRAME, REQ_WRITE} req_kind_t;
	typedef enum {SHAPE_LINE, SHAPE_LEFT, SHAPE_RIGHT, SHAPE_LOST, SHAPE_NOISE} shape_t;

	// one entry of the stimulus plan: either a frame or a register write
	typedef struct {
		req_kind_t            kind;
		zones_t               zones;
		logic [CFG_IDX_W-1:0] index;
		logic [GAIN_W-1:0]    data;
	} sensor_req_t;

	typedef struct {
		logic [DRIVE_W-1:0]      drive;
		logic signed [ERR_W-1:0] error;
		logic                    lost;
	} pid_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	zones_t                  zones_drv = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [DRIVE_W-1:0]      drive_value;
	logic signed [ERR_W-1:0] position_error;
	logic                    line_lost;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [GAIN_W-1:0]       cfg_data = '0;

	// stimulus plan and the drive results still owed by the block
	sensor_req_t sensor_plan[$];
	pid_out_t    predicted_pid[$];

	// predictor copy of the registers and the controller state
	logic signed [SP_W-1:0]  setpoint_q = SETPOINT_RST;
	logic [GAIN_W-1:0]       kp = GAIN_P_RST;
	logic [GAIN_W-1:0]       ki = GAIN_I_RST;
	logic [GAIN_W-1:0]       kd = GAIN_D_RST;
	logic signed [SUM_W-1:0] err_sum = '0;
	logic signed [ERR_W-1:0] prev_err = '0;

	// handshakes seen at the last rising edge, used by the falling edge driver
	logic in_took = 1'b0;
	logic cfg_took = 1'b0;

	int plan_frames = 0;
	int frames_in = 0;
	int writes_in = 0;
	int lost_seen = 0;
	int clipped = 0;
	int full_scale = 0;
	int mismatches = 0;
	int quiet_run = 0;
	int idle_cycles = 0;
	bit sum_top = 1'b0;
	bit sum_bottom = 1'b0;

	line_position_pid DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.zone_count_0   (zones_drv[0]),
		.zone_count_1   (zones_drv[1]),
		.zone_count_2   (zones_drv[2]),
		.zone_count_3   (zones_drv[3]),
		.zone_count_4   (zones_drv[4]),
		.zone_count_5   (zones_drv[5]),
		.zone_count_6   (zones_drv[6]),
		.zone_count_7   (zones_drv[7]),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_value    (drive_value),
		.position_error (position_error),
		.line_lost      (line_lost),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// one pid step for a frame: weighted centroid, error, error sum, drive value
	// updates the predictor state unless the line is lost
	function automatic pid_out_t track_line(input zones_t cnt);
		longint num, den, c, w, mag, q, centroid, raw, e, s, acc;
		pid_out_t r;
		num = 0;
		den = 0;
		for (int i = 0; i < ZONES; i++) begin
			// counts above the zone width clamp, weight never goes negative
			c = clip(cnt[i], 0, ZONE_W);
			w = ZONE_W - c;
			num += w * (OFFSET_BASE + SUBPIX * ZONE_W * (i + 1));
			den += w;
		end
		r.drive = '0;
		r.error = '0;
		r.lost = 1'b1;
		// no weight anywhere: line lost, state untouched
		if (den == 0)
			return r;
		// divide with halves rounded away from zero
		mag = num < 0 ? -num : num;
		q = (2 * mag + den) / (2 * den);
		centroid = num < 0 ? -q : q;
		raw = longint'(setpoint_q) - centroid;
		e = clip(raw, ERR_MIN, ERR_MAX);
		if (e != raw)
			clipped++;
		s = clip(longint'(err_sum) + e, SUM_MIN, SUM_MAX);
		if (s == SUM_MAX)
			sum_top = 1'b1;
		if (s == SUM_MIN)
			sum_bottom = 1'b1;
		acc = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - longint'(prev_err));
		r.lost = 1'b0;
		r.error = e[ERR_W-1:0];
		r.drive = acc <= 0 ? '0 : DRIVE_W'(clip(acc >>> DRIVE_SHIFT, 0, DRIVE_MAX));
		err_sum = s[SUM_W-1:0];
		prev_err = e[ERR_W-1:0];
		return r;
	endfunction

	function automatic zones_t uniform(input int v);
		zones_t z;
		for (int i = 0; i < ZONES; i++)
			z[i] = CNT_W'(v);
		return z;
	endfunction

	// a frame with a single zone fully on the line
	function automatic zones_t lone_zone(input int idx);
		zones_t z;
		z = uniform(ZONE_W);
		z[idx] = '0;
		return z;
	endfunction

	function automatic zones_t make_frame(input shape_t shape);
		zones_t z;
		int lo, span;
		case (shape)
			SHAPE_LINE: begin
				// dark band of one to three zones, zero weight elsewhere
				lo = $urandom_range(0, ZONES - 1);
				span = $urandom_range(1, 3);
				for (int i = 0; i < ZONES; i++)
					z[i] = CNT_W'((i >= lo && i < lo + span) ? $urandom_range(0, ZONE_W - 1)
						: $urandom_range(ZONE_W, CNT_MAX));
			end
			SHAPE_LEFT: begin
				// line stays in the two leftmost zones, never lost
				z = uniform(ZONE_W);
				for (int i = 0; i < ZONES; i++)
					z[i] = CNT_W'($urandom_range(ZONE_W, CNT_MAX));
				z[0] = CNT_W'($urandom_range(0, ZONE_W - 1));
				z[1] = CNT_W'($urandom_range(0, CNT_MAX));
			end
			SHAPE_RIGHT: begin
				for (int i = 0; i < ZONES; i++)
					z[i] = CNT_W'($urandom_range(ZONE_W, CNT_MAX));
				z[ZONES-1] = CNT_W'($urandom_range(0, ZONE_W - 1));
				z[ZONES-2] = CNT_W'($urandom_range(0, CNT_MAX));
			end
			SHAPE_LOST: begin
				for (int i = 0; i < ZONES; i++)
					z[i] = CNT_W'($urandom_range(ZONE_W, CNT_MAX));
			end
			default: begin
				for (int i = 0; i < ZONES; i++)
					z[i] = CNT_W'($urandom_range(0, CNT_MAX));
			end
		endcase
		return z;
	endfunction

	function automatic void add_frame(input zones_t z);
		sensor_req_t r;
		r.kind = REQ_FRAME;
		r.zones = z;
		r.index = '0;
		r.data = '0;
		sensor_plan.push_back(r);
		plan_frames++;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [GAIN_W-1:0] data);
		sensor_req_t r;
		r.kind = REQ_WRITE;
		r.zones = '0;
		r.index = idx;
		r.data = data;
		sensor_plan.push_back(r);
	endfunction

	// mostly small gains so the drive value lands inside the byte now and then
	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return GAIN_MAX;
			2, 3: return GAIN_W'($urandom_range(0, GAIN_MAX));
			default: return GAIN_W'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic void plan_gains();
		add_write(CFG_GAIN_P, random_gain());
		// integral gain is off at least half the time, the error sum swamps everything else
		add_write(CFG_GAIN_I, $urandom_range(0, 1) ? random_gain() : 16'h0000);
		add_write(CFG_GAIN_D, random_gain());
		if ($urandom_range(0, 1))
			add_write(CFG_IDX_W'(CFG_SPARE + $urandom_range(0, SPARE_SLOTS)),
				GAIN_W'($urandom_range(0, GAIN_MAX)));
	endfunction

	// plan the whole run, then release reset
	initial begin
		zones_t z;
		int r, sp;

		// directed: reset registers, flat field, lost frames, both edge zones
		add_frame(uniform(0));
		add_frame(uniform(ZONE_W));
		add_frame(uniform(CNT_MAX));
		add_frame(lone_zone(0));
		add_frame(lone_zone(ZONES - 1));
		// weight sum of 256 with a centroid of exactly 650.5, rounds up
		z = uniform(8);
		z[0] = CNT_W'(9);
		z[1] = CNT_W'(7);
		add_frame(z);
		// counts past the zone width clamp to zero weight
		z = uniform(0);
		z[2] = CNT_W'(ZONE_W + 1);
		z[5] = CNT_W'(CNT_MAX);
		z[6] = CNT_W'(ZONE_W);
		add_frame(z);

		// full gains, top setpoint: clipped error, saturated drive, lost frame in between
		add_write(CFG_SPARE, 16'hFFFF);
		add_write(CFG_SETPOINT, SP_MAX_DATA);
		add_write(CFG_GAIN_P, GAIN_MAX);
		add_write(CFG_GAIN_I, GAIN_MAX);
		add_write(CFG_GAIN_D, GAIN_MAX);
		add_frame(lone_zone(0));
		add_frame(uniform(CNT_MAX));
		add_frame(lone_zone(ZONES - 1));
		add_frame(lone_zone(0));

		// bottom setpoint with all gains off: clipped negative error, zero drive
		add_write(CFG_SETPOINT, SP_MIN_DATA);
		add_write(CFG_GAIN_P, 16'h0000);
		add_write(CFG_GAIN_I, 16'h0000);
		add_write(CFG_GAIN_D, 16'h0000);
		add_frame(lone_zone(ZONES - 1));
		add_frame(lone_zone(0));

		// derivative only, line swinging edge to edge
		add_write(CFG_SETPOINT, 16'h0000);
		add_write(CFG_GAIN_D, GAIN_MAX);
		add_frame(lone_zone(0));
		add_frame(lone_zone(ZONES - 1));
		add_frame(lone_zone(0));

		// upper setpoint bits are don't care, this lands on the reset value
		add_write(CFG_SETPOINT, 16'hE250);
		add_write(CFG_GAIN_P, GAIN_P_RST);
		add_write(CFG_GAIN_D, 16'h0000);

		// long drift left of the setpoint winds the error sum far up
		add_write(CFG_SETPOINT, SP_MAX_DATA);
		plan_gains();
		for (int n = 0; n < RISE_FRAMES; n++)
			add_frame(make_frame(SHAPE_LEFT));

		// and back down well below zero
		add_write(CFG_SETPOINT, SP_MIN_DATA);
		plan_gains();
		for (int n = 0; n < FALL_FRAMES; n++)
			add_frame(make_frame(SHAPE_RIGHT));

		// general segments, new setpoint and gains each time
		for (int g = 0; g < SEGMENTS; g++) begin
			if ($urandom_range(0, 1)) begin
				add_write(CFG_SETPOINT, GAIN_W'($urandom_range(0, GAIN_MAX)));
			end else begin
				sp = int'($urandom_range(0, CENTROID_HI - CENTROID_LO)) + CENTROID_LO;
				add_write(CFG_SETPOINT, sp[GAIN_W-1:0]);
			end
			plan_gains();
			for (int n = 0; n < SEG_FRAMES; n++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					add_frame(make_frame(SHAPE_LINE));
				else if (r < 75)
					add_frame(make_frame(SHAPE_NOISE));
				else if (r < 85)
					add_frame(make_frame(SHAPE_LOST));
				else if (r < 93)
					add_frame(make_frame(SHAPE_LEFT));
				else
					add_frame(make_frame(SHAPE_RIGHT));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: every request taken and every result back, then a quiet tail
		while (sensor_plan.size() != 0 || in_valid || cfg_valid || predicted_pid.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("covered %0d frames (%0d line lost, %0d with the error clipped), %0d writes",
			frames_in, lost_seen, clipped, writes_in);
		$display("drive pinned at full scale %0d times, error sum at top rail %0d, bottom rail %0d",
			full_scale, sum_top, sum_bottom);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// driver: falling edge, one entry of the plan at a time
	// register writes wait until no result is owed and the block has sat quiet a while
	always @(negedge clk) begin : driver
		sensor_req_t head;
		logic frame_up, write_up;
		int tx_idle_pct, rx_idle_pct;
		frame_up = in_valid && !in_took;
		write_up = cfg_valid && !cfg_took;
		// idling profile by thirds of the run: sender light, then receiver light, then none
		case (frames_in * 3 / plan_frames)
			0: begin
				tx_idle_pct = 9;
				rx_idle_pct = 61;
			end
			1: begin
				tx_idle_pct = 61;
				rx_idle_pct = 9;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		endcase
		if (arst_n) begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			if (!frame_up && !write_up && sensor_plan.size() != 0) begin
				head = sensor_plan[0];
				if (head.kind == REQ_WRITE) begin
					if (quiet_run >= DRAIN_CYC) begin
						cfg_index <= head.index;
						cfg_data <= head.data;
						write_up = 1'b1;
						void'(sensor_plan.pop_front());
					end
				end else if ($urandom_range(0, 99) >= tx_idle_pct) begin
					zones_drv <= head.zones;
					frame_up = 1'b1;
					void'(sensor_plan.pop_front());
				end
			end
			in_valid <= frame_up;
			cfg_valid <= write_up;
			quiet_run <= (frame_up || predicted_pid.size() != 0) ? 0 : quiet_run + 1;
		end
	end

	// monitor: rising edge, predicts on each accepted frame and checks each result
	always @(posedge clk) begin : monitor
		pid_out_t want;
		in_took <= arst_n && in_valid && !in_stall;
		cfg_took <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			// register write lands in the predictor copy, unused indexes do nothing
			if (cfg_valid && cfg_ready) begin
				writes_in++;
				case (cfg_index)
					CFG_SETPOINT: setpoint_q = cfg_data[SP_W-1:0];
					CFG_GAIN_P: kp = cfg_data;
					CFG_GAIN_I: ki = cfg_data;
					CFG_GAIN_D: kd = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predicted_pid.push_back(track_line(zones_drv));
				frames_in++;
			end
			if (out_valid && !out_stall) begin
				if (predicted_pid.size() == 0) begin
					$error("result with nothing owed: drive_value %0d position_error %0d line_lost %0b",
						drive_value, position_error, line_lost);
					mismatches++;
				end else begin
					want = predicted_pid.pop_front();
					if (want.lost)
						lost_seen++;
					if (want.drive == DRIVE_MAX)
						full_scale++;
					if (drive_value !== want.drive) begin
						$error("drive_value: expected %0d, actual %0d", want.drive, drive_value);
						mismatches++;
					end
					if (position_error !== want.error) begin
						$error("position_error: expected %0d, actual %0d",
							want.error, position_error);
						mismatches++;
					end
					if (line_lost !== want.lost) begin
						$error("line_lost: expected %0b, actual %0b", want.lost, line_lost);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog: too long without any request or result moving ends the run
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d frames taken, %0d results owed",
				idle_cycles, frames_in, predicted_pid.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
